### hw/rtl/lts_pkg.sv
`default_nettype none

package lts_pkg;

   // Fixed field widths.
   localparam int PitchW     = 14;
   localparam int ToneW      = 15;
   localparam int DurW       = 20;
   localparam int LockBitsW  = 4;
   localparam int TenthsW    = 4;
   localparam int CsrIndexW  = 3;
   localparam int CsrDataW   = 14;
   localparam int PhysLocks  = 4;

   // Defaults for the top level parameters.
   localparam int LockCountDefault  = 4;
   localparam int TuneLengthDefault = 4;

   localparam logic [DurW-1:0] UsPerTenth = DurW'(100000);
   localparam logic [TenthsW-1:0] TenthsMin = TenthsW'(1);
   localparam logic [TenthsW-1:0] TenthsMax = TenthsW'(10);

   // Register indexes on the configuration port.
   localparam logic [CsrIndexW-1:0] CSR_BEEP_MODE    = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_CAPS_PITCH   = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_INSERT_PITCH = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_NUMBER_PITCH = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_SCROLL_PITCH = 3'd4;
   localparam logic [CsrIndexW-1:0] CSR_TONE_TENTHS  = 3'd5;

   // Register reset values.
   localparam logic                PlayModeReset   = 1'b1;
   localparam logic [PitchW-1:0]   CapsPitchReset  = 14'd300;
   localparam logic [PitchW-1:0]   InsPitchReset   = 14'd450;
   localparam logic [PitchW-1:0]   NumPitchReset   = 14'd600;
   localparam logic [PitchW-1:0]   ScrPitchReset   = 14'd1200;
   localparam logic [TenthsW-1:0]  TenthsReset     = 4'd2;

   // Play modes.
   localparam logic MODE_ACTIVE = 1'b0;
   localparam logic MODE_TOGGLE = 1'b1;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_START = 2'd1,
      ACT_STOP  = 2'd2
   } action_type;

   typedef struct packed {
      logic                 op;
      logic [LockBitsW-1:0] lock_bits;
   } req_type;

   typedef struct packed {
      action_type       action;
      logic [ToneW-1:0] tone_pitch;
      logic [DurW-1:0]  duration_us;
   } rsp_type;

   typedef struct packed {
      logic                             beep_mode;
      logic [PhysLocks-1:0][PitchW-1:0] lock_pitch;
      logic [TenthsW-1:0]               tone_tenths;
   } cfg_type;

   // Base pitch of a lock; locks past the physical four are off.
   function automatic logic [PitchW-1:0] pitch_of(input cfg_type cfg, input logic [2:0] lock);
      logic [PitchW-1:0] p;
      p = '0;
      if (lock < 3'(PhysLocks)) begin
         p = cfg.lock_pitch[lock[1:0]];
      end
      return p;
   endfunction

   // pitch * (100 + pct) / 100 with pct of 0, 25, 50 or 100. Since 25 and 50
   // percent are a quarter and a half, the floor reduces to a shifted add.
   function automatic logic [ToneW-1:0] tone_scale(input logic [PitchW-1:0] p,
                                                   input logic [2:0] idx);
      logic [ToneW-1:0] r;
      case (idx)
         3'd0:    r = ToneW'(p);
         3'd1:    r = ToneW'(p) + ToneW'(p >> 2);
         3'd2:    r = ToneW'(p) + ToneW'(p >> 1);
         default: r = ToneW'(p) + ToneW'(p);
      endcase
      return r;
   endfunction

   // Final tone length in microseconds, tenths clamped to one through ten.
   function automatic logic [DurW-1:0] final_us(input logic [TenthsW-1:0] tenths);
      logic [TenthsW-1:0] t;
      t = tenths;
      if (t < TenthsMin) t = TenthsMin;
      if (t > TenthsMax) t = TenthsMax;
      return DurW'(DurW'(t) * UsPerTenth);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/lock_tone_sequencer.sv
`default_nettype none

// Channel     Direction  Handshake             Payload
// req         in         req_valid/req_ready   req_data  (op, lock_bits)
// rsp         out        rsp_valid/rsp_ready   rsp_data  (action, tone_pitch, duration_us)
// csr         in         csr_we (no wait)      csr_index, csr_wdata
//
// A request transaction is accepted only in the idle state. After acceptance its result
// may pass the round-robin scan state, which visits up to NUM_LOCKS locks, and the tone
// state, entered when a toggle-mode tone is generated; the emit state then hands it to
// the output register and the sequencer returns to idle.
// The scan examines one lock per cycle through a single shared compare unit.
// Reset is synchronous and active high; it restores register defaults and clears the
// sequencer control state, not the result registers. A stalled result waits in the
// output register; the next request can be accepted meanwhile and waits in the emit state.

module lock_tone_sequencer #(
   parameter int NUM_LOCKS   = lts_pkg::LockCountDefault,
   parameter int TUNE_LENGTH = lts_pkg::TuneLengthDefault
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire lts_pkg::req_type               req_data,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      lts_pkg::rsp_type               rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [lts_pkg::CsrIndexW-1:0]  csr_index,
   input  wire logic [lts_pkg::CsrDataW-1:0]   csr_wdata
);
   import lts_pkg::*;

   localparam int PtrW  = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
   localparam int StepW = (TUNE_LENGTH > 1) ? $clog2(TUNE_LENGTH) : 1;
   localparam logic [PtrW-1:0]  LastLock = PtrW'(NUM_LOCKS - 1);
   localparam logic [StepW-1:0] LastStep = StepW'(TUNE_LENGTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_TONE = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   cfg_type cfg;

   lts_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   state_type                state_ff, state_in;
   logic [LockBitsW-1:0]     seen_ff, seen_in;
   logic [NUM_LOCKS-1:0]     announced_ff, announced_in;
   logic [PtrW-1:0]          ptr_ff, ptr_in;
   logic [PtrW-1:0]          cnt_ff, cnt_in;
   logic                     pend_ff, pend_in;
   logic [PtrW-1:0]          tlock_ff, tlock_in;
   logic [StepW-1:0]         tstep_ff, tstep_in;
   logic                     tdesc_ff, tdesc_in;
   rsp_type                  res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // Shared examine unit: looks at the lock under the scan pointer.
   logic [2:0]        scan_lock;
   logic [PitchW-1:0] scan_pitch;
   logic              scan_bit;
   logic              scan_was;
   logic              scan_hit;
   logic [PtrW-1:0]   ptr_next;

   // Tone unit: pitch and length of the next tune tone.
   logic [PitchW-1:0] tone_base;
   logic [StepW-1:0]  tone_idx;
   logic [ToneW-1:0]  note_pitch;
   logic              tone_last;
   logic [DurW-1:0]   full_us;

   always_comb begin
      scan_lock  = 3'(ptr_ff);
      scan_pitch = pitch_of(cfg, scan_lock);
      scan_bit   = (scan_lock < 3'(PhysLocks)) ? seen_ff[scan_lock[1:0]] : 1'b0;
      scan_was   = announced_ff[ptr_ff];
      if (cfg.beep_mode == MODE_ACTIVE) begin
         scan_hit = scan_bit && (scan_pitch != '0);
      end else begin
         scan_hit = (scan_bit != scan_was) && (scan_pitch != '0);
      end
      ptr_next   = (ptr_ff == LastLock) ? '0 : ptr_ff + PtrW'(1);

      tone_base  = pitch_of(cfg, 3'(tlock_ff));
      tone_idx   = tdesc_ff ? (LastStep - tstep_ff) : tstep_ff;
      note_pitch = tone_scale(tone_base, 3'(tone_idx));
      tone_last  = (tstep_ff == LastStep);
      full_us    = final_us(cfg.tone_tenths);
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      seen_in      = seen_ff;
      announced_in = announced_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      tlock_in     = tlock_ff;
      tstep_in     = tstep_ff;
      tdesc_in     = tdesc_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               res_in = '{action: ACT_NONE, tone_pitch: '0, duration_us: '0};
               if (req_data.op) begin
                  // Tone finished: play the next tone of a tune or rescan.
                  state_in = pend_ff ? ST_TONE : ST_SCAN;
               end else if (req_data.lock_bits == seen_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  seen_in = req_data.lock_bits;
                  if (cfg.beep_mode == MODE_ACTIVE) begin
                     if (req_data.lock_bits == '0) begin
                        res_in.action = ACT_STOP;
                        state_in      = ST_EMIT;
                     end else if (seen_ff == '0) begin
                        state_in = pend_ff ? ST_TONE : ST_SCAN;
                     end else begin
                        // The running tone cycle continues undisturbed.
                        state_in = ST_EMIT;
                     end
                  end else begin
                     state_in = pend_ff ? ST_TONE : ST_SCAN;
                  end
               end
            end
         end

         ST_SCAN: begin
            ptr_in = ptr_next;
            cnt_in = cnt_ff + PtrW'(1);
            if (cfg.beep_mode == MODE_TOGGLE && scan_bit != scan_was) begin
               // The change is recorded even when the lock's pitch is off.
               announced_in[ptr_ff] = scan_bit;
            end
            if (scan_hit) begin
               if (cfg.beep_mode == MODE_ACTIVE) begin
                  res_in   = '{action: ACT_START, tone_pitch: ToneW'(scan_pitch),
                               duration_us: full_us};
                  state_in = ST_EMIT;
               end else begin
                  pend_in  = 1'b1;
                  tlock_in = ptr_ff;
                  tstep_in = '0;
                  tdesc_in = !scan_bit;
                  state_in = ST_TONE;
               end
            end else if (cnt_ff == LastLock) begin
               res_in   = '{action: ACT_STOP, tone_pitch: '0, duration_us: '0};
               state_in = ST_EMIT;
            end
         end

         ST_TONE: begin
            res_in = '{action: ACT_START, tone_pitch: note_pitch,
                       duration_us: tone_last ? full_us : (full_us >> 1)};
            if (tone_last) begin
               pend_in  = 1'b0;
               tstep_in = '0;
            end else begin
               tstep_in = tstep_ff + StepW'(1);
            end
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         announced_ff <= '0;
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         tlock_ff     <= '0;
         tstep_ff     <= '0;
         tdesc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         announced_ff <= announced_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         tlock_ff     <= tlock_in;
         tstep_ff     <= tstep_in;
         tdesc_ff     <= tdesc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A new result only appears after the emit state has handed it over.
   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result appeared without passing the emit state");

   // Tone generation is only entered with a tune pending.
   a_tone_needs_tune: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TONE) |-> pend_ff)
      else $error("tone state entered without a pending tune");

   // A started tone always has a nonzero length.
   a_start_has_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.action == ACT_START) |-> (rsp_data_ff.duration_us != '0))
      else $error("tone started with zero duration");

   // The scan never visits more locks than there are.
   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= LastLock))
      else $error("lock scan ran past the last lock");

   // The tune step stays inside the tune.
   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (tstep_ff <= LastStep))
      else $error("tune step beyond tune length");

endmodule

`default_nettype wire

### hw/rtl/lts_csr_regs.sv
`default_nettype none

module lts_csr_regs (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [lts_pkg::CsrIndexW-1:0]  csr_index,
   input  wire logic [lts_pkg::CsrDataW-1:0]   csr_wdata,
   output lts_pkg::cfg_type                    cfg
);
   import lts_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BEEP_MODE:    cfg_in.beep_mode     = csr_wdata[0];
            CSR_CAPS_PITCH:   cfg_in.lock_pitch[0] = csr_wdata[PitchW-1:0];
            CSR_INSERT_PITCH: cfg_in.lock_pitch[1] = csr_wdata[PitchW-1:0];
            CSR_NUMBER_PITCH: cfg_in.lock_pitch[2] = csr_wdata[PitchW-1:0];
            CSR_SCROLL_PITCH: cfg_in.lock_pitch[3] = csr_wdata[PitchW-1:0];
            CSR_TONE_TENTHS:  cfg_in.tone_tenths   = csr_wdata[TenthsW-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.beep_mode     <= PlayModeReset;
         cfg_ff.lock_pitch[0] <= CapsPitchReset;
         cfg_ff.lock_pitch[1] <= InsPitchReset;
         cfg_ff.lock_pitch[2] <= NumPitchReset;
         cfg_ff.lock_pitch[3] <= ScrPitchReset;
         cfg_ff.tone_tenths   <= TenthsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire
